FILE: rtl/core/counting_multiset_table_unit_macros.svh
// Assertion macros shared by the counting multiset table unit.
`ifndef COUNTING_MULTISET_TABLE_UNIT_MACROS_SVH
`define COUNTING_MULTISET_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CMTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CMTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cmtu_pkg.sv
// Types and constants of the counting multiset table unit.
package cmtu_pkg;

    localparam int REQ_TYPE_W   = 3;
    localparam int ITEM_VALUE_W = 32;
    localparam int SLOT_INDEX_W = 5;
    localparam int COUNT_OUT_W  = 16;
    localparam int VALUE_OUT_W  = 32;
    localparam int TOTAL_W      = 21;
    localparam int DISTINCT_W   = 6;

    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ERASE     = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_ERASE_ALL = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY     = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_GET       = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic                    ok;
        logic [COUNT_OUT_W-1:0]  count_out;
        logic [VALUE_OUT_W-1:0]  value_out;
        logic [TOTAL_W-1:0]      total_items;
        logic [DISTINCT_W-1:0]   distinct_items;
    } rsp_payload_t;

endpackage

FILE: rtl/core/cmtu_req_if.sv
// Request channel: valid/ready handshake with request fields.
interface cmtu_req_if;
    import cmtu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [ITEM_VALUE_W-1:0] item_value;
    logic [SLOT_INDEX_W-1:0] slot_index;

    modport source (output valid, req_type, item_value, slot_index, input ready);
    modport sink   (input valid, req_type, item_value, slot_index, output ready);
endinterface

FILE: rtl/core/cmtu_rsp_if.sv
// Response channel: valid/ready handshake with result fields.
interface cmtu_rsp_if;
    import cmtu_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [COUNT_OUT_W-1:0] count_out;
    logic [VALUE_OUT_W-1:0] value_out;
    logic [TOTAL_W-1:0]     total_items;
    logic [DISTINCT_W-1:0]  distinct_items;

    modport source (output valid, ok, count_out, value_out, total_items, distinct_items,
                    input ready);
    modport sink   (input valid, ok, count_out, value_out, total_items, distinct_items,
                    output ready);
endinterface

FILE: rtl/core/counting_multiset_table_unit.sv
// Top level of the counting multiset table unit.
//
//   channel | dir | fields
//   --------+-----+-------------------------------------------------------------
//   req     | in  | req_type, item_value, slot_index
//   rsp     | out | ok, count_out, value_out, total_items, distinct_items
//
// In the accept cycle all live slots are compared against the value and the lowest
// hit (or lowest free slot; a get reads its slot index) starts the count/value RAM read;
// in the update state the slot is updated and the result loaded into the output register.
// A full output register holds the update cycle until the result is taken.
// Reset clears the live bits, totals and control at once; no clearing pass.
module counting_multiset_table_unit #(
    parameter int ENTRIES     = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    cmtu_req_if.sink   req,
    cmtu_rsp_if.source rsp
);
    import cmtu_pkg::*;

    cmd_t         cmd;
    rsp_payload_t rsp_data;

    cmtu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    cmtu_datapath #(
        .ENTRIES     (ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req.req_type),
        .item_value (req.item_value),
        .slot_index (req.slot_index),
        .rsp_data   (rsp_data)
    );

    assign rsp.ok             = rsp_data.ok;
    assign rsp.count_out      = rsp_data.count_out;
    assign rsp.value_out      = rsp_data.value_out;
    assign rsp.total_items    = rsp_data.total_items;
    assign rsp.distinct_items = rsp_data.distinct_items;
endmodule

FILE: rtl/core/cmtu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: rtl/core/cmtu_ctrl.sv
// Controller: sequences capture and commit of each item, owns the output valid.
`include "counting_multiset_table_unit_macros.svh"

module cmtu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output cmtu_pkg::cmd_t cmd
);
    import cmtu_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // output register must be free, or emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `CMTU_ASSERT_NEXT(a_capture_to_update, clk, rst_n, cmd.capture, state_reg == ST_UPDATE, "capture did not lead to update")
    `CMTU_ASSERT_NEXT(a_commit_loads_out, clk, rst_n, cmd.commit, out_valid_reg, "commit did not load output")
    `CMTU_ASSERT_NEXT(a_update_holds, clk, rst_n, (state_reg == ST_UPDATE) && out_valid_reg && !out_ready, state_reg == ST_UPDATE, "update left while output blocked")
endmodule

FILE: rtl/core/cmtu_datapath.sv
// Datapath: parallel live-entry compare, count/value RAMs, totals and output register.
`include "counting_multiset_table_unit_macros.svh"

module cmtu_datapath #(
    parameter int ENTRIES     = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cmtu_pkg::cmd_t                      cmd,
    input  logic [cmtu_pkg::REQ_TYPE_W-1:0]     req_type,
    input  logic [cmtu_pkg::ITEM_VALUE_W-1:0]   item_value,
    input  logic [cmtu_pkg::SLOT_INDEX_W-1:0]   slot_index,
    output cmtu_pkg::rsp_payload_t              rsp_data
);
    import cmtu_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int DW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // value tags, each compared at its own place
    logic [VALUE_WIDTH-1:0] cam_reg [ENTRIES];
    logic [ENTRIES-1:0]     live_reg, live_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [DW-1:0]          distinct_reg, distinct_next;

    logic [REQ_TYPE_W-1:0]  req_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   found_reg;
    logic                   free_reg;
    logic                   get_ok_reg;
    logic [IW-1:0]          slot_reg;
    rsp_payload_t           rsp_reg;

    logic [VALUE_WIDTH-1:0] value_in;
    logic [ENTRIES-1:0]     match_vec;
    logic [IW-1:0]          match_idx, free_idx, idx_sel, rd_addr;
    logic                   found, has_free, get_ok_in;

    logic [COUNT_WIDTH-1:0] count_rdata, cnt_inc, cnt_dec, cnt_wr_data, res_cnt;
    logic [VALUE_WIDTH-1:0] value_rdata, res_val;
    logic                   cnt_wr_en, val_wr_en, res_ok;

    // ---- compare and slot selection, in the accept cycle ----
    assign value_in = VALUE_WIDTH'(item_value);
    assign idx_sel  = IW'(slot_index);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = live_reg[i] && (cam_reg[i] == value_in);
        end
    end

    // lowest index wins: scan downwards so the last hit stands
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = IW'(i);
            end
            if (!live_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign found     = |match_vec;
    assign has_free  = ~&live_reg;
    assign get_ok_in = (32'(slot_index) < 32'(ENTRIES))
                    && (32'(slot_index) < 32'(distinct_reg))
                    && live_reg[idx_sel];
    assign rd_addr   = (req_type == REQ_GET) ? idx_sel : (found ? match_idx : free_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= req_type;
            value_reg  <= value_in;
            found_reg  <= found;
            free_reg   <= has_free;
            get_ok_reg <= get_ok_in;
            slot_reg   <= rd_addr;
        end
    end

    cmtu_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (ENTRIES)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && cnt_wr_en),
        .wr_addr (slot_reg),
        .wr_data (cnt_wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (count_rdata)
    );

    cmtu_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && val_wr_en),
        .wr_addr (slot_reg),
        .wr_data (value_reg),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (value_rdata)
    );

    // ---- read-modify-write of the chosen slot ----
    assign cnt_inc = count_rdata + COUNT_WIDTH'(1);
    assign cnt_dec = count_rdata - COUNT_WIDTH'(1);

    always_comb
    begin
        live_next     = live_reg;
        total_next    = total_reg;
        distinct_next = distinct_reg;
        cnt_wr_en     = 1'b0;
        cnt_wr_data   = count_rdata;
        val_wr_en     = 1'b0;
        res_ok        = 1'b0;
        res_cnt       = '0;
        res_val       = '0;
        unique case (req_reg)
            REQ_INSERT:
            begin
                if (found_reg)
                begin
                    res_cnt = count_rdata;
                    if (count_rdata != COUNT_MAX)
                    begin
                        cnt_wr_en   = 1'b1;
                        cnt_wr_data = cnt_inc;
                        total_next  = total_reg + TOTAL_W'(1);
                        res_ok      = 1'b1;
                        res_cnt     = cnt_inc;
                    end
                end
                else if (free_reg)
                begin
                    cnt_wr_en           = 1'b1;
                    cnt_wr_data         = COUNT_WIDTH'(1);
                    val_wr_en           = 1'b1;
                    live_next[slot_reg] = 1'b1;
                    total_next          = total_reg + TOTAL_W'(1);
                    distinct_next       = distinct_reg + DW'(1);
                    res_ok              = 1'b1;
                    res_cnt             = COUNT_WIDTH'(1);
                end
            end
            REQ_ERASE:
            begin
                if (found_reg)
                begin
                    cnt_wr_en   = 1'b1;
                    cnt_wr_data = cnt_dec;
                    total_next  = total_reg - TOTAL_W'(1);
                    if (cnt_dec == '0)
                    begin
                        live_next[slot_reg] = 1'b0;
                        distinct_next       = distinct_reg - DW'(1);
                    end
                    res_ok  = 1'b1;
                    res_cnt = cnt_dec;
                end
            end
            REQ_ERASE_ALL:
            begin
                if (found_reg)
                begin
                    // live bit cleared is enough: a dead slot reads as zero
                    live_next[slot_reg] = 1'b0;
                    total_next          = total_reg - TOTAL_W'(count_rdata);
                    distinct_next       = distinct_reg - DW'(1);
                    res_ok              = 1'b1;
                    res_cnt             = count_rdata;
                end
            end
            REQ_QUERY:
            begin
                if (found_reg)
                begin
                    res_ok  = 1'b1;
                    res_cnt = count_rdata;
                end
            end
            REQ_GET:
            begin
                if (get_ok_reg)
                begin
                    res_ok  = 1'b1;
                    res_cnt = count_rdata;
                    res_val = value_rdata;
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            total_reg    <= '0;
            distinct_reg <= '0;
        end
        else if (cmd.commit)
        begin
            live_reg     <= live_next;
            total_reg    <= total_next;
            distinct_reg <= distinct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && val_wr_en)
        begin
            cam_reg[slot_reg] <= value_reg;
        end
        if (cmd.commit)
        begin
            rsp_reg.ok             <= res_ok;
            rsp_reg.count_out      <= COUNT_OUT_W'(res_cnt);
            rsp_reg.value_out      <= VALUE_OUT_W'(res_val);
            rsp_reg.total_items    <= total_next;
            rsp_reg.distinct_items <= DISTINCT_W'(distinct_next);
        end
    end

    assign rsp_data = rsp_reg;

    `CMTU_ASSERT_IMPLY(a_unique_live_value, clk, rst_n, 1'b1, $onehot0(match_vec), "value held by two live slots")
    `CMTU_ASSERT_IMPLY(a_distinct_matches_live, clk, rst_n, 1'b1, $countones(live_reg) == distinct_reg, "distinct count out of step with live slots")
    `CMTU_ASSERT_NEXT(a_erase_all_kills, clk, rst_n, cmd.commit && (req_reg == REQ_ERASE_ALL) && found_reg, !live_reg[slot_reg], "erase all left slot live")
endmodule
